// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the queue and emitter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MTT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define MTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `MTT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Check that a trigger implies a condition in the next cycle.
`define MTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    `MTT_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== sv/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and constants of the MD tag tokenizer.
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int QUEUE_DEPTH_LOG2 = 2;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_MATCH = 3'd0;
    localparam t_kind KIND_DEL   = 3'd1;
    localparam t_kind KIND_A     = 3'd2;
    localparam t_kind KIND_C     = 3'd3;
    localparam t_kind KIND_G     = 3'd4;
    localparam t_kind KIND_T     = 3'd5;

    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // One queue entry: present, and holding a second record.
    typedef struct packed {
        logic valid;
        logic two;
    } t_ent_ctl;

endpackage

// ===== sv/md_tag_tokenizer.sv =====
// ----------------------------------------------------------------------------
// md_tag_tokenizer
// Turns the characters of an MD alignment tag into alignment records.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive i_symbol/i_final_char with i_push; a
//   character is taken at an edge where i_push is high and o_full is low.
//   Result side is a queue: while o_empty is low the oldest record is on
//   o_record_kind/o_record_length/o_run_end; i_pop takes it.
//   Each character yields zero, one or two records; o_run_end marks the
//   last record of a character.
//   The records of a character enter the queue as one entry at the edge
//   that takes the character, then load into the output word when it is
//   free or being popped. Throughput: one character per cycle while o_full
//   is low; the output word moves one record per cycle unless the receiver
//   stalls; the extra record of a character that yields two records is
//   absorbed by a four-entry queue between classifier and emitter.
//   Reset (synchronous, i_rst_n low) clears the parse state, the queue and
//   the output word. When the receiver stalls, the output word holds and the
//   queue fills; o_full rises once four entries wait.
// ----------------------------------------------------------------------------
module md_tag_tokenizer #(
    parameter int LENGTH_BITS = mtt_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [7:0]             i_symbol,
    input  logic                   i_final_char,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [2:0]             o_record_kind,
    output logic [LENGTH_BITS-1:0] o_record_length,
    output logic                   o_run_end
);

    mtt_pkg::t_ent_ctl      wr_ctl;
    mtt_pkg::t_kind         wr_kind0, wr_kind1;
    logic [LENGTH_BITS-1:0] wr_len0, wr_len1;
    mtt_pkg::t_ent_ctl      head_ctl;
    mtt_pkg::t_kind         hd_kind0, hd_kind1;
    logic [LENGTH_BITS-1:0] hd_len0, hd_len1;
    logic                   q_rd;

    mtt_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_symbol     (i_symbol),
        .i_final_char (i_final_char),
        .i_full       (o_full),
        .o_wr         (wr_ctl),
        .o_kind0      (wr_kind0),
        .o_len0       (wr_len0),
        .o_kind1      (wr_kind1),
        .o_len1       (wr_len1)
    );

    mtt_queue #(.LENGTH_BITS(LENGTH_BITS)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr_ctl),
        .i_kind0 (wr_kind0),
        .i_len0  (wr_len0),
        .i_kind1 (wr_kind1),
        .i_len1  (wr_len1),
        .i_rd    (q_rd),
        .o_full  (o_full),
        .o_head  (head_ctl),
        .o_kind0 (hd_kind0),
        .o_len0  (hd_len0),
        .o_kind1 (hd_kind1),
        .o_len1  (hd_len1)
    );

    mtt_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_ctl),
        .i_kind0         (hd_kind0),
        .i_len0          (hd_len0),
        .i_kind1         (hd_kind1),
        .i_len1          (hd_len1),
        .o_rd            (q_rd),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_record_kind   (o_record_kind),
        .o_record_length (o_record_length),
        .o_run_end       (o_run_end)
    );

endmodule

// ===== sv/mtt_front.sv =====
// ----------------------------------------------------------------------------
// mtt_front
// Classifies each character, updates the parse state and forms up to two
// records per character as one queue entry.
// ----------------------------------------------------------------------------
module mtt_front #(
    parameter int LENGTH_BITS = mtt_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [7:0]             i_symbol,
    input  logic                   i_final_char,
    input  logic                   i_full,
    output mtt_pkg::t_ent_ctl      o_wr,
    output mtt_pkg::t_kind         o_kind0,
    output logic [LENGTH_BITS-1:0] o_len0,
    output mtt_pkg::t_kind         o_kind1,
    output logic [LENGTH_BITS-1:0] o_len1
);

    localparam int WB = LENGTH_BITS + 4;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

    logic [LENGTH_BITS-1:0] r_num, n_num;
    logic                   r_pending, n_pending;
    logic                   r_in_del, n_in_del;
    logic [LENGTH_BITS-1:0] r_del_cnt, n_del_cnt;

    logic                   accept;
    logic [7:0]             sym_u;
    logic                   is_digit;
    logic [WB-1:0]          num_x10;
    logic [LENGTH_BITS-1:0] num_step;
    logic                   is_base;
    mtt_pkg::t_kind         base_kind;
    logic                   c1_v, c2_v;
    mtt_pkg::t_kind         c1_kind, c2_kind;
    logic [LENGTH_BITS-1:0] c1_len, c2_len;

    assign accept = i_push && !i_full;

    always_comb begin
        if (i_symbol inside {[mtt_pkg::CH_LA:mtt_pkg::CH_LZ]}) begin
            sym_u = i_symbol - mtt_pkg::CASE_GAP;
        end else begin
            sym_u = i_symbol;
        end
        is_digit = sym_u inside {[mtt_pkg::CH_0:mtt_pkg::CH_9]};
    end

    // Decimal accumulate with saturation: value * 8 + value * 2 + digit.
    always_comb begin
        num_x10 = ({{4{1'b0}}, r_num} << 3) + ({{4{1'b0}}, r_num} << 1)
                + {{LENGTH_BITS{1'b0}}, sym_u[3:0]};
        if (!r_pending || r_in_del) begin
            num_step = {{(LENGTH_BITS-4){1'b0}}, sym_u[3:0]};
        end else if (num_x10[WB-1:LENGTH_BITS] != 4'd0) begin
            num_step = LEN_MAX;
        end else begin
            num_step = num_x10[LENGTH_BITS-1:0];
        end
    end

    always_comb begin
        is_base   = 1'b1;
        base_kind = mtt_pkg::KIND_A;
        case (sym_u)
            mtt_pkg::CH_A: base_kind = mtt_pkg::KIND_A;
            mtt_pkg::CH_C: base_kind = mtt_pkg::KIND_C;
            mtt_pkg::CH_G: base_kind = mtt_pkg::KIND_G;
            mtt_pkg::CH_T: base_kind = mtt_pkg::KIND_T;
            default:       is_base   = 1'b0;
        endcase
    end

    always_comb begin
        n_num     = r_num;
        n_pending = r_pending;
        n_in_del  = r_in_del;
        n_del_cnt = r_del_cnt;
        c1_v      = 1'b0;
        c1_kind   = mtt_pkg::KIND_MATCH;
        c1_len    = r_num;
        c2_v      = 1'b0;
        c2_kind   = mtt_pkg::KIND_MATCH;
        c2_len    = num_step;
        if (is_digit) begin
            // A digit closes an open deletion and starts or extends a number.
            c1_v      = r_in_del;
            c1_kind   = mtt_pkg::KIND_DEL;
            c1_len    = r_del_cnt;
            n_in_del  = 1'b0;
            n_del_cnt = '0;
            n_num     = num_step;
            n_pending = 1'b1;
            c2_v      = i_final_char;
        end else if (r_in_del) begin
            if (r_del_cnt != LEN_MAX) begin
                n_del_cnt = r_del_cnt + LEN_ONE;
            end
        end else begin
            c1_v      = r_pending;
            n_pending = 1'b0;
            n_num     = '0;
            c2_v      = is_base;
            c2_kind   = base_kind;
            c2_len    = LEN_ONE;
            if (sym_u == mtt_pkg::CH_CARET) begin
                n_in_del  = 1'b1;
                n_del_cnt = '0;
            end
        end
        if (i_final_char) begin
            n_num     = '0;
            n_pending = 1'b0;
            n_in_del  = 1'b0;
            n_del_cnt = '0;
        end
    end

    // Compact the two candidates into the entry.
    always_comb begin
        o_wr.valid = accept && (c1_v || c2_v);
        o_wr.two   = c1_v && c2_v;
        if (c1_v) begin
            o_kind0 = c1_kind;
            o_len0  = c1_len;
        end else begin
            o_kind0 = c2_kind;
            o_len0  = c2_len;
        end
        o_kind1 = c2_kind;
        o_len1  = c2_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num     <= '0;
            r_pending <= 1'b0;
            r_in_del  <= 1'b0;
            r_del_cnt <= '0;
        end else if (accept) begin
            r_num     <= n_num;
            r_pending <= n_pending;
            r_in_del  <= n_in_del;
            r_del_cnt <= n_del_cnt;
        end
    end

endmodule

// ===== sv/mtt_queue.sv =====
// ----------------------------------------------------------------------------
// mtt_queue
// Short entry queue between the classifier and the record emitter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtt_queue #(
    parameter int LENGTH_BITS = mtt_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mtt_pkg::t_ent_ctl      i_wr,
    input  mtt_pkg::t_kind         i_kind0,
    input  logic [LENGTH_BITS-1:0] i_len0,
    input  mtt_pkg::t_kind         i_kind1,
    input  logic [LENGTH_BITS-1:0] i_len1,
    input  logic                   i_rd,
    output logic                   o_full,
    output mtt_pkg::t_ent_ctl      o_head,
    output mtt_pkg::t_kind         o_kind0,
    output logic [LENGTH_BITS-1:0] o_len0,
    output mtt_pkg::t_kind         o_kind1,
    output logic [LENGTH_BITS-1:0] o_len1
);

    localparam int AW = mtt_pkg::QUEUE_DEPTH_LOG2;
    localparam int DEPTH = 1 << AW;
    localparam logic [AW:0] COUNT_FULL = (AW+1)'(DEPTH);

    mtt_pkg::t_kind         r_kind0 [DEPTH];
    logic [LENGTH_BITS-1:0] r_len0  [DEPTH];
    mtt_pkg::t_kind         r_kind1 [DEPTH];
    logic [LENGTH_BITS-1:0] r_len1  [DEPTH];
    logic                   r_two   [DEPTH];
    logic [AW-1:0]          r_wr_ptr;
    logic [AW-1:0]          r_rd_ptr;
    logic [AW:0]            r_count;
    logic                   do_rd;

    assign o_full      = (r_count == COUNT_FULL);
    assign do_rd       = i_rd && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.two  = r_two[r_rd_ptr];
    assign o_kind0     = r_kind0[r_rd_ptr];
    assign o_len0      = r_len0[r_rd_ptr];
    assign o_kind1     = r_kind1[r_rd_ptr];
    assign o_len1      = r_len1[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_kind0[r_wr_ptr] <= i_kind0;
            r_len0[r_wr_ptr]  <= i_len0;
            r_kind1[r_wr_ptr] <= i_kind1;
            r_len1[r_wr_ptr]  <= i_len1;
            r_two[r_wr_ptr]   <= i_wr.two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_wr.valid && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr.valid && do_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `MTT_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_wr.valid, !o_full, "queue write while full")
    `MTT_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= COUNT_FULL, "queue count out of range")

endmodule

// ===== sv/mtt_back.sv =====
// ----------------------------------------------------------------------------
// mtt_back
// Serializes queue entries into single records and holds the output word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtt_back #(
    parameter int LENGTH_BITS = mtt_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mtt_pkg::t_ent_ctl      i_head,
    input  mtt_pkg::t_kind         i_kind0,
    input  logic [LENGTH_BITS-1:0] i_len0,
    input  mtt_pkg::t_kind         i_kind1,
    input  logic [LENGTH_BITS-1:0] i_len1,
    output logic                   o_rd,
    input  logic                   i_pop,
    output logic                   o_empty,
    output mtt_pkg::t_kind         o_record_kind,
    output logic [LENGTH_BITS-1:0] o_record_length,
    output logic                   o_run_end
);

    logic                   r_out_valid;
    logic                   r_sel;
    mtt_pkg::t_kind         r_kind;
    logic [LENGTH_BITS-1:0] r_len;
    logic                   r_end;
    logic                   take;
    logic                   head_pair;

    // Load the next record when the output word is free or being popped.
    assign take = i_head.valid && (!r_out_valid || i_pop);
    assign o_rd = take && (!i_head.two || r_sel);
    assign head_pair = i_head.valid && i_head.two;

    assign o_empty         = !r_out_valid;
    assign o_record_kind   = r_kind;
    assign o_record_length = r_len;
    assign o_run_end       = r_end;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind <= r_sel ? i_kind1 : i_kind0;
            r_len  <= r_sel ? i_len1 : i_len0;
            r_end  <= !i_head.two || r_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sel       <= 1'b0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
                r_sel       <= i_head.two && !r_sel;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `MTT_ASSERT_IMP(a_sel_on_pair, i_clk, i_rst_n, r_sel, head_pair, "select without pair")
    `MTT_ASSERT_NXT(a_sel_clears, i_clk, i_rst_n, take && r_sel, !r_sel, "select stuck")

endmodule
